@@ hdl/clr_pkg.sv @@
// shared types and constants for the cell list relink block
// no dependencies; imported by clr_ctrl, clr_datapath and cell_list_relink
package clr_pkg;

  localparam int DEF_MAX_PARTICLES = 8192;
  localparam int DEF_NUM_CELLS     = 4096;

  // fixed field widths of the transaction payload
  localparam int PART_W = 13;
  localparam int CELL_W = 12;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;    // write one entry of the clearing pass
    logic accept;    // capture input transaction, issue memory reads
    logic look;      // read data valid: decide, unlink or mark placed
    logic push;      // link particle at head of target cell
    logic fix;       // back link of the former first particle
    logic load_out;  // load the result register
  } clr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_done;  // last entry of the clearing pass
    logic act;       // particle is inserted or moved (valid during look)
  } clr_status_t;

endpackage

@@ hdl/clr_ctrl.sv @@
// sequencer for the cell list relink block: clearing pass, per-transaction
// steps and the result handshake; depends on clr_pkg
module clr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  clr_pkg::clr_status_t status,
  output clr_pkg::clr_cmd_t    cmd
);
  import clr_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_PUSH  = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = status.act ? ST_PUSH : ST_OUT;
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/clr_datapath.sv @@
// link memories, clearing counter, write port steering and result register
// of the cell list relink block; depends on clr_pkg
module clr_datapath #(
  parameter int MAX_PARTICLES = clr_pkg::DEF_MAX_PARTICLES,
  parameter int NUM_CELLS     = clr_pkg::DEF_NUM_CELLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  clr_pkg::clr_cmd_t           cmd,
  output clr_pkg::clr_status_t        status,
  input  logic [clr_pkg::PART_W-1:0]  in_particle,
  input  logic [clr_pkg::CELL_W-1:0]  in_target_cell,
  output logic [clr_pkg::CELL_W-1:0]  out_cell_now,
  output logic                        out_relinked
);
  import clr_pkg::*;

  localparam int PW        = $clog2(MAX_PARTICLES);
  localparam int LW        = $clog2(MAX_PARTICLES + 1);
  localparam int CW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CLR_DEPTH = (NUM_CELLS > MAX_PARTICLES) ? NUM_CELLS : MAX_PARTICLES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [LW-1:0]    LINK_EMPTY = LW'(MAX_PARTICLES);
  localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_DEPTH - 1);

  // memories
  logic [LW-1:0] head_mem   [NUM_CELLS];
  logic [LW-1:0] next_mem   [MAX_PARTICLES];
  logic [LW-1:0] prev_mem   [MAX_PARTICLES];
  logic [CW-1:0] home_mem   [MAX_PARTICLES];
  logic          placed_mem [MAX_PARTICLES];

  // read data
  logic [LW-1:0] head_rd_r, next_rd_r, prev_rd_r;
  logic [CW-1:0] home_rd_r;
  logic          placed_rd_r;

  // captured transaction
  logic [PW-1:0]     p_r;
  logic [CELL_W-1:0] cell_r;
  logic              ok_r;
  logic              act_r;
  logic [CELL_W-1:0] out_cell_now_r;
  logic              out_relinked_r;

  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_done;

  logic [31:0]   part_ext, cell_ext, cell_r_ext;
  logic [PW-1:0] rd_part_addr;
  logic [CW-1:0] rd_cell_addr, cell_idx;
  logic [LW-1:0] p_link;
  logic          diff, act, move, nx_valid, pv_valid, first_valid;
  logic          clr_cell_ok, clr_part_ok;

  logic          head_we, placed_we, home_we, next_we, prev_we;
  logic [CW-1:0] head_addr;
  logic [PW-1:0] placed_addr, home_addr, next_addr, prev_addr;
  logic [LW-1:0] head_wdata, next_wdata, prev_wdata;
  logic          placed_wdata;

  assign part_ext     = 32'(in_particle);
  assign cell_ext     = 32'(in_target_cell);
  assign rd_part_addr = part_ext[PW-1:0];
  assign rd_cell_addr = cell_ext[CW-1:0];
  assign cell_r_ext   = 32'(cell_r);
  assign cell_idx     = cell_r_ext[CW-1:0];
  assign p_link       = LW'(p_r);

  assign diff        = (home_rd_r != cell_idx);
  assign act         = ok_r && (!placed_rd_r || diff);
  assign move        = ok_r && placed_rd_r && diff;
  assign nx_valid    = (next_rd_r != LINK_EMPTY);
  assign pv_valid    = (prev_rd_r != LINK_EMPTY);
  assign first_valid = (head_rd_r != LINK_EMPTY);

  // clearing pass over the larger of the two reset-valued stores
  assign clr_done    = (clr_cnt_r == CLR_LAST);
  assign clr_cell_ok = (32'(clr_cnt_r) < 32'(NUM_CELLS));
  assign clr_part_ok = (32'(clr_cnt_r) < 32'(MAX_PARTICLES));
  assign clr_cnt_nxt = (cmd.clr_wr && !clr_done) ? clr_cnt_r + 1'b1 : clr_cnt_r;

  assign status.clr_done = clr_done;
  assign status.act      = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // head store: clear, unlink at old head, push at new head
  always_comb begin
    head_we    = 1'b0;
    head_addr  = cell_idx;
    head_wdata = p_link;
    if (cmd.clr_wr) begin
      head_we    = clr_cell_ok;
      head_addr  = clr_cnt_r[CW-1:0];
      head_wdata = LINK_EMPTY;
    end else if (cmd.look && move && !pv_valid) begin
      head_we    = 1'b1;
      head_addr  = home_rd_r;
      head_wdata = next_rd_r;
    end else if (cmd.push) begin
      head_we = 1'b1;
    end
  end

  // placed bits and home cell
  always_comb begin
    placed_we    = 1'b0;
    placed_addr  = p_r;
    placed_wdata = 1'b1;
    if (cmd.clr_wr) begin
      placed_we    = clr_part_ok;
      placed_addr  = clr_cnt_r[PW-1:0];
      placed_wdata = 1'b0;
    end else if (cmd.look && act) begin
      placed_we = 1'b1;
    end
  end

  assign home_we   = cmd.look && act;
  assign home_addr = p_r;

  // forward links
  always_comb begin
    next_we    = 1'b0;
    next_addr  = p_r;
    next_wdata = head_rd_r;
    if (cmd.look && move && pv_valid) begin
      next_we    = 1'b1;
      next_addr  = prev_rd_r[PW-1:0];
      next_wdata = next_rd_r;
    end else if (cmd.push) begin
      next_we = 1'b1;
    end
  end

  // back links: unlink, new head, former first particle
  always_comb begin
    prev_we    = 1'b0;
    prev_addr  = p_r;
    prev_wdata = LINK_EMPTY;
    if (cmd.look && move && nx_valid) begin
      prev_we    = 1'b1;
      prev_addr  = next_rd_r[PW-1:0];
      prev_wdata = prev_rd_r;
    end else if (cmd.push) begin
      prev_we = 1'b1;
    end else if (cmd.fix && first_valid) begin
      prev_we    = 1'b1;
      prev_addr  = head_rd_r[PW-1:0];
      prev_wdata = p_link;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_addr] <= head_wdata;
    if (cmd.accept) head_rd_r <= head_mem[rd_cell_addr];
  end

  always_ff @(posedge clk) begin
    if (placed_we) placed_mem[placed_addr] <= placed_wdata;
    if (cmd.accept) placed_rd_r <= placed_mem[rd_part_addr];
  end

  always_ff @(posedge clk) begin
    if (home_we) home_mem[home_addr] <= cell_idx;
    if (cmd.accept) home_rd_r <= home_mem[rd_part_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_addr] <= next_wdata;
    if (cmd.accept) next_rd_r <= next_mem[rd_part_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_addr] <= prev_wdata;
    if (cmd.accept) prev_rd_r <= prev_mem[rd_part_addr];
  end

  // transaction capture and result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r    <= rd_part_addr;
      cell_r <= in_target_cell;
      ok_r   <= (part_ext < 32'(MAX_PARTICLES)) && (cell_ext < 32'(NUM_CELLS));
    end
    if (cmd.look) act_r <= act;
    if (cmd.load_out) begin
      out_cell_now_r <= cell_r;
      out_relinked_r <= act_r;
    end
  end

  assign out_cell_now = out_cell_now_r;
  assign out_relinked = out_relinked_r;

endmodule

@@ hdl/cell_list_relink.sv @@
// top level of the cell list relink block
// depends on clr_pkg, clr_ctrl and clr_datapath
//
// Keeps one doubly linked list of particles per cell in on-chip memories and
// moves a particle between lists on each input transaction. An unplaced
// particle is pushed at the head of its target cell; a placed particle whose
// cell differs is unlinked and pushed at the head of the new cell; a
// particle already in the named cell, or a particle or cell index beyond the
// configured range, changes nothing. Each input transaction gives exactly
// one result transaction carrying the target cell and a relinked flag.
// After reset the block runs a clearing pass of max(NUM_CELLS,
// MAX_PARTICLES) entries (8192 with the defaults) that empties the cell heads
// and placed bits; in_stall stays high until it ends. An insert or move then
// runs through accept and read, look-up and unlink, push and back-link fix
// before the result register is loaded; a transaction that changes nothing
// skips push and fix. The back-link memory sets the step order: its single
// write port takes up to three writes per move. A new input transaction is
// taken while the previous result still waits in the output register.
module cell_list_relink #(
  parameter int MAX_PARTICLES = clr_pkg::DEF_MAX_PARTICLES,
  parameter int NUM_CELLS     = clr_pkg::DEF_NUM_CELLS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [clr_pkg::PART_W-1:0] in_particle,
  input  logic [clr_pkg::CELL_W-1:0] in_target_cell,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [clr_pkg::CELL_W-1:0] out_cell_now,
  output logic                       out_relinked
);
  import clr_pkg::*;

  // command and status between sequencer and datapath
  clr_cmd_t    cmd;
  clr_status_t status;

  // sequencer: clearing pass, step order, result handshake
  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // memories, write steering and the result register
  clr_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .NUM_CELLS     (NUM_CELLS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_particle    (in_particle),
    .in_target_cell (in_target_cell),
    .out_cell_now   (out_cell_now),
    .out_relinked   (out_relinked)
  );

  // a result is never loaded over one the receiver has not taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // the back-link fix always follows the push step
  a_fix_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |-> $past(cmd.push))
    else $error("back-link fix without preceding push");

  // no result leaves the block during the clearing pass
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> (!out_valid && in_stall))
    else $error("handshake active during clearing pass");

endmodule
